// ===== design/delta_list_timeout_queue_unit_defines.svh =====
// Assertion macros for the timeout queue unit.
`ifndef DELTA_LIST_TIMEOUT_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_TIMEOUT_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DLTQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dltq_pkg.sv =====
// Shared types and constants of the delta-list timeout queue.
`default_nettype none
package dltq_pkg;

	localparam logic [31:0] DELTA_ENDLESS = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;   // borrow on subtract
		logic        zero;
	} alu_rsp_t;

endpackage
`default_nettype wire

// ===== design/dltq_alu.sv =====
// Shared 32-bit add/subtract unit with borrow and zero flags.
`default_nettype none
module dltq_alu
	import dltq_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [32:0] res;

	always_comb begin
		case (req.op)
			ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
			default: res = '0;
		endcase
		rsp.sum   = res[31:0];
		rsp.carry = res[32];
		rsp.zero  = (res[31:0] == 32'd0);
	end

endmodule
`default_nettype wire

// ===== design/delta_list_timeout_queue_unit.sv =====
// Top level: delta-list timeout queue with list-walking sequencer.
// Usage:
//   Command channel: operation/task_slot/timeout_ms are taken at a clock edge with
//   start high and busy low. busy stays high until the command's result is out.
//   Result channel: done is high for exactly one cycle with status, expired_valid
//   and expired_slot; the receiver must take it then, it cannot stall the block.
// Insert and delete walk the list, one entry per cycle through the registered
// slot memory read port, visiting up to TASK_SLOTS entries. An insert rebases
// the following entry's delta when it goes in front of it, and skips the walk
// on an empty queue or an endless timeout; a delete hands its delta to the
// successor. A tick on an empty queue and a rejected command end at decode.
// A new command can be given in the cycle that done is shown.
// One add/subtract unit serves the walk compare, the rebase, the delta
// hand-back and the tick decrement.
// Reset empties the queue at once; the delta and link memories are not
// cleared, as only queued slots are ever read.
`default_nettype none
`include "delta_list_timeout_queue_unit_defines.svh"
module delta_list_timeout_queue_unit
	import dltq_pkg::*;
#(
	parameter int TASK_SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [4:0]         task_slot,
	input  logic signed [31:0] timeout_ms,
	output logic               done,
	output logic [1:0]         status,
	output logic               expired_valid,
	output logic [4:0]         expired_slot
);

	localparam int SW = $clog2(TASK_SLOTS);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_WALK, S_REBASE, S_LINK_A, S_LINK_B,
		S_DSCAN, S_DFIX, S_TCHK
	} state_t;

	state_t state_q;

	logic [1:0]            op_q;
	logic                  slot_ok_q;
	logic [SW-1:0]         s_q;
	logic [31:0]           t_q;
	logic [SW-1:0]         cur_q, pred_q, succ_q;
	logic                  has_pred_q, has_succ_q;
	logic [SW-1:0]         head_q, tail_q;
	logic                  nonempty_q;
	logic [TASK_SLOTS-1:0] has_next_q, in_queue_q;

	logic                  done_q, exp_valid_q;
	logic [1:0]            status_q;
	logic [4:0]            exp_slot_q;

	// slot memories
	logic [31:0]   delta_mem [TASK_SLOTS];
	logic [SW-1:0] link_mem  [TASK_SLOTS];
	logic [31:0]   delta_rd_q;
	logic [SW-1:0] link_rd_q;

	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic          dm_we, lm_we;
	logic [SW-1:0] dm_wa, lm_wa;
	logic [31:0]   dm_wd;
	logic [SW-1:0] lm_wd;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic walk_more;

	dltq_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk) begin
		if (dm_we)
			delta_mem[dm_wa] <= dm_wd;
		if (lm_we)
			link_mem[lm_wa] <= lm_wd;
		if (rd_en) begin
			delta_rd_q <= delta_mem[rd_addr];
			link_rd_q  <= link_mem[rd_addr];
		end
	end

	// walk goes on only when the new entry lies past this one and more follow
	assign walk_more = !delta_rd_q[31] && !alu_rsp.carry && !alu_rsp.zero
		&& has_next_q[cur_q];

	always_comb begin
		alu_req = '{op: ALU_SUB, a: t_q, b: delta_rd_q};
		rd_en   = 1'b0;
		rd_addr = link_rd_q;
		dm_we   = 1'b0;
		dm_wa   = s_q;
		dm_wd   = t_q;
		lm_we   = 1'b0;
		lm_wa   = s_q;
		lm_wd   = succ_q;
		case (state_q)
			S_DECODE: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			S_WALK: begin
				rd_en = walk_more;
			end
			S_REBASE: begin
				alu_req = '{op: ALU_SUB, a: delta_rd_q, b: t_q};
				dm_we   = 1'b1;
				dm_wa   = cur_q;
				dm_wd   = alu_rsp.sum;
			end
			S_LINK_A: begin
				dm_we = 1'b1;
				lm_we = has_succ_q;
			end
			S_LINK_B: begin
				lm_we = has_pred_q;
				lm_wa = pred_q;
				lm_wd = s_q;
			end
			S_DSCAN: begin
				rd_en = 1'b1;
			end
			S_DFIX: begin
				alu_req = '{op: ALU_ADD, a: delta_rd_q, b: t_q};
				dm_we   = !delta_rd_q[31] && !t_q[31];
				dm_wa   = succ_q;
				dm_wd   = alu_rsp.sum;
				lm_we   = has_pred_q;
				lm_wa   = pred_q;
				lm_wd   = succ_q;
			end
			S_TCHK: begin
				alu_req = '{op: ALU_SUB, a: delta_rd_q, b: {31'd0, |delta_rd_q}};
				dm_we   = !delta_rd_q[31];
				dm_wa   = head_q;
				dm_wd   = alu_rsp.sum;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			nonempty_q  <= 1'b0;
			has_next_q  <= '0;
			in_queue_q  <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			exp_valid_q <= 1'b0;
			exp_slot_q  <= '0;
			op_q        <= '0;
			slot_ok_q   <= 1'b0;
			s_q         <= '0;
			t_q         <= '0;
			cur_q       <= '0;
			pred_q      <= '0;
			succ_q      <= '0;
			has_pred_q  <= 1'b0;
			has_succ_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= operation;
						slot_ok_q <= ({27'd0, task_slot} < 32'(TASK_SLOTS));
						s_q       <= SW'(task_slot);
						t_q       <= timeout_ms;
						state_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					exp_valid_q <= 1'b0;
					exp_slot_q  <= '0;
					cur_q       <= head_q;
					has_pred_q  <= 1'b0;
					has_succ_q  <= 1'b0;
					case (op_q)
						OP_INSERT: begin
							if (!slot_ok_q || in_queue_q[s_q]) begin
								done_q   <= 1'b1;
								status_q <= ST_INVALID;
								state_q  <= S_IDLE;
							end else if (t_q == DELTA_ENDLESS) begin
								// endless tasks append at the tail
								has_pred_q <= nonempty_q;
								pred_q     <= tail_q;
								state_q    <= S_LINK_A;
							end else if (t_q[31]) begin
								done_q   <= 1'b1;
								status_q <= ST_INVALID;
								state_q  <= S_IDLE;
							end else if (!nonempty_q) begin
								state_q <= S_LINK_A;
							end else begin
								state_q <= S_WALK;
							end
						end
						OP_DELETE: begin
							if (!slot_ok_q || !in_queue_q[s_q]) begin
								done_q   <= 1'b1;
								status_q <= ST_INVALID;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_DSCAN;
							end
						end
						OP_TICK: begin
							if (!nonempty_q) begin
								done_q   <= 1'b1;
								status_q <= ST_NONE;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_TCHK;
							end
						end
						default: begin
							done_q   <= 1'b1;
							status_q <= ST_INVALID;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_WALK: begin
					if (delta_rd_q[31]) begin
						has_succ_q <= 1'b1;
						succ_q     <= cur_q;
						state_q    <= S_LINK_A;
					end else if (alu_rsp.carry) begin
						has_succ_q <= 1'b1;
						succ_q     <= cur_q;
						state_q    <= S_REBASE;
					end else begin
						t_q        <= alu_rsp.sum;
						has_pred_q <= 1'b1;
						pred_q     <= cur_q;
						if (alu_rsp.zero) begin
							// equal time: goes right after this entry
							has_succ_q <= has_next_q[cur_q];
							succ_q     <= link_rd_q;
							state_q    <= S_LINK_A;
						end else if (has_next_q[cur_q]) begin
							cur_q <= link_rd_q;
						end else begin
							state_q <= S_LINK_A;
						end
					end
				end
				S_REBASE: begin
					state_q <= S_LINK_A;
				end
				S_LINK_A: begin
					has_next_q[s_q] <= has_succ_q;
					in_queue_q[s_q] <= 1'b1;
					nonempty_q      <= 1'b1;
					if (!has_succ_q)
						tail_q <= s_q;
					state_q <= S_LINK_B;
				end
				S_LINK_B: begin
					if (has_pred_q)
						has_next_q[pred_q] <= 1'b1;
					else
						head_q <= s_q;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				S_DSCAN: begin
					if (cur_q == s_q) begin
						if (has_next_q[s_q]) begin
							t_q     <= delta_rd_q;
							succ_q  <= link_rd_q;
							state_q <= S_DFIX;
						end else begin
							if (has_pred_q) begin
								has_next_q[pred_q] <= 1'b0;
								tail_q             <= pred_q;
							end else begin
								nonempty_q <= 1'b0;
								head_q     <= '0;
								tail_q     <= '0;
							end
							in_queue_q[s_q] <= 1'b0;
							done_q          <= 1'b1;
							status_q        <= ST_OK;
							state_q         <= S_IDLE;
						end
					end else if (has_next_q[cur_q]) begin
						has_pred_q <= 1'b1;
						pred_q     <= cur_q;
						cur_q      <= link_rd_q;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_INVALID;
						state_q  <= S_IDLE;
					end
				end
				S_DFIX: begin
					if (!has_pred_q)
						head_q <= succ_q;
					has_next_q[s_q] <= 1'b0;
					in_queue_q[s_q] <= 1'b0;
					done_q          <= 1'b1;
					status_q        <= ST_OK;
					state_q         <= S_IDLE;
				end
				S_TCHK: begin
					done_q   <= 1'b1;
					status_q <= ST_NONE;
					state_q  <= S_IDLE;
					if (!delta_rd_q[31] && alu_rsp.zero) begin
						status_q    <= ST_OK;
						exp_valid_q <= 1'b1;
						exp_slot_q  <= 5'(head_q);
						in_queue_q[head_q] <= 1'b0;
						has_next_q[head_q] <= 1'b0;
						if (has_next_q[head_q]) begin
							head_q <= link_rd_q;
						end else begin
							nonempty_q <= 1'b0;
							head_q     <= '0;
							tail_q     <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign expired_valid = exp_valid_q;
	assign expired_slot  = exp_slot_q;

	`DLTQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
	`DLTQ_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`DLTQ_ASSERT_NOW(a_expired_ok, done && expired_valid, status == ST_OK, "expiry without ok status")
	`DLTQ_ASSERT_NOW(a_empty_clear, !nonempty_q, in_queue_q == '0, "empty queue holds queued slots")

endmodule
`default_nettype wire
